// File: src/mrw_pkg.sv
// ----------------------------------------------------------------------------
// mrw_pkg
// Shared widths, verdict codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package mrw_pkg;

   localparam int NUM_WIDTH = 64;
   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

   localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
   localparam logic [1:0] VERDICT_PROBABLE  = 2'd1;
   localparam logic [1:0] VERDICT_INVALID   = 2'd2;

   // datapath operations
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1; // latch n, a; start exponent split
   localparam logic [2:0] OP_SHIFT  = 3'd2; // strip one trailing zero of t
   localparam logic [2:0] OP_MUL_AX = 3'd3; // start acc * base
   localparam logic [2:0] OP_MUL_BB = 3'd4; // start base * base
   localparam logic [2:0] OP_MUL_XX = 3'd5; // start acc * acc
   localparam logic [2:0] OP_NEXT_E = 3'd6; // drop low exponent bit

   typedef struct packed {
      logic [2:0] op;
   } cmd_type;

   typedef struct packed {
      logic invalid;    // candidate or witness out of range
      logic t_even;     // t still even during split
      logic e_zero;     // exponent exhausted
      logic e_lsb;      // current exponent bit
      logic mul_busy;   // modular product running
      logic x_one;      // acc == 1
      logic x_nm1;      // acc == n-1
      logic s_more;     // squarings left
   } status_type;

endpackage

// File: src/mrw_datapath.sv
// ----------------------------------------------------------------------------
// mrw_datapath
// Operand registers, exponent split and a shift-and-add modular multiplier
// that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mrw_datapath
   import mrw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [63:0]          req_candidate,
   input  logic [63:0]          req_witness,
   input  cmd_type              cmd,
   output status_type           status
);

   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] base_ff, base_in;   // a^(2^k) mod n
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;     // running result x
   logic [NUM_WIDTH-1:0] exp_ff, exp_in;     // remaining exponent t
   logic [CNT_WIDTH-1:0] s_ff, s_in;         // s after split; one more than squarings left
   logic                 inv_ff, inv_in;

   // multiplier state
   logic                 busy_ff, busy_in;
   logic                 dst_acc_ff, dst_acc_in;
   logic [NUM_WIDTH-1:0] mp_ff, mp_in;       // partial sum
   logic [NUM_WIDTH-1:0] mb_ff, mb_in;       // doubled multiplicand
   logic [NUM_WIDTH-1:0] my_ff, my_in;       // multiplier bits left

   logic [NUM_WIDTH-1:0] n_w, a_w, nm1;
   logic [NUM_WIDTH-1:0] sum_gap, dbl_gap, sum_v, dbl_v;

   assign n_w = req_candidate[NUM_WIDTH-1:0];
   assign a_w = req_witness[NUM_WIDTH-1:0];
   assign nm1 = n_ff - NUM_WIDTH'(1);

   // modular add of partial sum and multiplicand, and doubling
   always_comb begin
      sum_gap = n_ff - mb_ff;
      sum_v   = (mp_ff >= sum_gap) ? (mp_ff - sum_gap) : (mp_ff + mb_ff);
      dbl_gap = n_ff - mb_ff;
      dbl_v   = (mb_ff >= dbl_gap) ? (mb_ff - dbl_gap) : (mb_ff + mb_ff);
   end

   always_comb begin
      n_in       = n_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      exp_in     = exp_ff;
      s_in       = s_ff;
      inv_in     = inv_ff;
      busy_in    = busy_ff;
      dst_acc_in = dst_acc_ff;
      mp_in      = mp_ff;
      mb_in      = mb_ff;
      my_in      = my_ff;

      // advance a running product by one multiplier bit
      if (busy_ff) begin
         if (my_ff == '0) begin
            busy_in = 1'b0;
            if (dst_acc_ff) acc_in = mp_ff;
            else            base_in = mp_ff;
         end else begin
            if (my_ff[0]) mp_in = sum_v;
            mb_in = dbl_v;
            my_in = my_ff >> 1;
         end
      end

      unique case (cmd.op)
         OP_LOAD: begin
            n_in    = n_w;
            base_in = a_w;
            acc_in  = NUM_WIDTH'(1);
            exp_in  = n_w - NUM_WIDTH'(1);
            s_in    = '0;
            inv_in  = !n_w[0] || (n_w < NUM_WIDTH'(5)) || (a_w < NUM_WIDTH'(2))
                      || (a_w > n_w - NUM_WIDTH'(2));
         end
         OP_SHIFT: begin
            exp_in = exp_ff >> 1;
            s_in   = s_ff + CNT_WIDTH'(1);
         end
         OP_MUL_AX: begin
            busy_in = 1'b1; dst_acc_in = 1'b1;
            mp_in = '0; mb_in = acc_ff; my_in = base_ff;
         end
         OP_MUL_BB: begin
            busy_in = 1'b1; dst_acc_in = 1'b0;
            mp_in = '0; mb_in = base_ff; my_in = base_ff;
         end
         OP_MUL_XX: begin
            busy_in = 1'b1; dst_acc_in = 1'b1;
            mp_in = '0; mb_in = acc_ff; my_in = acc_ff;
            s_in  = s_ff - CNT_WIDTH'(1);
         end
         OP_NEXT_E: begin
            exp_in = exp_ff >> 1;
         end
         OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      n_ff       <= n_in;
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      exp_ff     <= exp_in;
      s_ff       <= s_in;
      inv_ff     <= inv_in;
      dst_acc_ff <= dst_acc_in;
      mp_ff      <= mp_in;
      mb_ff      <= mb_in;
      my_ff      <= my_in;
   end

   // s_ff counts s during split; one squaring fewer than s follows
   assign status.invalid  = inv_ff;
   assign status.t_even   = !exp_ff[0];
   assign status.e_zero   = (exp_ff == '0);
   assign status.e_lsb    = exp_ff[0];
   assign status.mul_busy = busy_ff;
   assign status.x_one    = (acc_ff == NUM_WIDTH'(1));
   assign status.x_nm1    = (acc_ff == nm1);
   assign status.s_more   = (s_ff > CNT_WIDTH'(1));

endmodule

// File: src/mrw_control.sv
// ----------------------------------------------------------------------------
// mrw_control
// Sequencer: split n-1, square-and-multiply, trailing squarings, verdict.
// ----------------------------------------------------------------------------
module mrw_control
   import mrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   input  status_type  status,
   output cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SPLIT = 3'd1;
   localparam logic [2:0] ST_EXP   = 3'd2;
   localparam logic [2:0] ST_SQB   = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_SQX   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       vld_ff, vld_in;
   logic [1:0] verdict_ff, verdict_in;
   logic       sq_ff, sq_in;   // base squaring issued in SQB, or in trailing squarings

   assign req_ready   = (state_ff == ST_IDLE) && !vld_ff;
   assign rsp_valid   = vld_ff;
   assign rsp_verdict = verdict_ff;

   always_comb begin
      state_in   = state_ff;
      vld_in     = vld_ff;
      verdict_in = verdict_ff;
      sq_in      = sq_ff;
      cmd.op     = OP_NONE;
      if (vld_ff && rsp_ready) vld_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.op   = OP_LOAD;
               state_in = ST_SPLIT;
               sq_in    = 1'b0;
            end
         end
         ST_SPLIT: begin
            if (status.invalid) begin
               verdict_in = VERDICT_INVALID;
               state_in   = ST_DONE;
            end else if (status.t_even) begin
               cmd.op = OP_SHIFT;
            end else begin
               state_in = ST_EXP;
            end
         end
         // one exponent bit: optional acc*base then base*base; check once exhausted
         ST_EXP: begin
            if (!status.mul_busy) begin
               if (status.e_zero) begin
                  state_in = ST_CHECK;
               end else if (status.e_lsb) begin
                  cmd.op   = OP_MUL_AX;
                  state_in = ST_SQB;
               end else begin
                  cmd.op   = OP_MUL_BB;
                  state_in = ST_SQB;
               end
            end
         end
         // base squaring still owed after an acc*base step, then drop exponent bit
         ST_SQB: begin
            if (!status.mul_busy) begin
               if (status.e_lsb && !sq_ff) begin
                  cmd.op = OP_MUL_BB;
                  sq_in  = 1'b1;
               end else begin
                  cmd.op   = OP_NEXT_E;
                  sq_in    = 1'b0;
                  state_in = ST_EXP;
               end
            end
         end
         ST_CHECK: begin
            if (!status.mul_busy) begin
               if (status.x_nm1 || (!sq_ff && status.x_one)) begin
                  verdict_in = VERDICT_PROBABLE;
                  state_in   = ST_DONE;
               end else if (sq_ff && status.x_one) begin
                  verdict_in = VERDICT_COMPOSITE;
                  state_in   = ST_DONE;
               end else if (status.s_more) begin
                  cmd.op   = OP_MUL_XX;
                  sq_in    = 1'b1;
                  state_in = ST_SQX;
               end else begin
                  verdict_in = VERDICT_COMPOSITE;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_SQX: begin
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (!vld_ff) begin
               vld_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
         sq_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         sq_ff    <= sq_in;
      end
      verdict_ff <= verdict_in;
   end

`ifndef SYNTH
   // a result only waits while the sequencer is idle
   a_vld_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE)) else $error("bad state");
   // no new item while a result waits
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   // verdict code 3 never shown
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict != 2'd3) else $error("bad verdict");
`endif

endmodule

// File: src/miller_rabin_witness_test_unit.sv
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_unit
// Strong probable-prime test of one candidate against one witness.
//
//  channel | ports                              | direction
//  req     | req_valid/ready, candidate, witness| in
//  rsp     | rsp_valid/ready, verdict           | out
//
// One item at a time. Each modular product runs in the shift-and-add
// multiplier; the bits of t and the trailing squarings together number
// at most NUM_WIDTH-1, so an item needs at most 2*NUM_WIDTH products.
// Invalid inputs finish without any modular product. Reset is
// synchronous, active high. A result waits in its register until taken;
// no new item enters meanwhile.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test_unit
   import mrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_candidate,
   input  logic [63:0] req_witness,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict
);

   cmd_type    cmd;
   status_type status;

   mrw_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .rsp_verdict, .status, .cmd
   );

   mrw_datapath u_datapath (
      .clock, .reset, .req_candidate, .req_witness, .cmd, .status
   );

endmodule

// File: bench/mrw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrw_checker
// Watches the request and response channels of the witness test unit,
// computes the expected verdict of every request transfer and compares it
// with each response transfer in order. Reports mismatches and counts them.
// ----------------------------------------------------------------------------
module mrw_checker
   import mrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [63:0] req_candidate,
   input  logic [63:0] req_witness,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_verdict,
   output int          fail_count,
   output int          verdicts_pending
);

   typedef logic [NUM_WIDTH-1:0] num_type;

   logic [1:0] verdict_queue[$];

   // (x * y) mod m with a double-width product
   function automatic num_type mod_product(num_type x, num_type y, num_type m);
      logic [2*NUM_WIDTH-1:0] full;
      full = x * y;
      full = full % m;
      return full[NUM_WIDTH-1:0];
   endfunction

   // b^e mod m by square-and-multiply
   function automatic num_type mod_power(num_type b, num_type e, num_type m);
      num_type acc;
      acc = num_type'(1);
      while (e != 0) begin
         if (e[0])
            acc = mod_product(acc, b, m);
         b = mod_product(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // strong probable-prime verdict for one candidate and one witness
   function automatic logic [1:0] witness_verdict(num_type n, num_type a);
      num_type odd_part;
      num_type x;
      num_type n_less_one;
      int      twos;
      if (!n[0] || n < 5)
         return VERDICT_INVALID;
      if (a < 2 || a > n - 2)
         return VERDICT_INVALID;
      n_less_one = n - num_type'(1);
      odd_part = n_less_one;
      twos = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      x = mod_power(a, odd_part, n);
      if (x == 1 || x == n_less_one)
         return VERDICT_PROBABLE;
      for (int i = 1; i < twos; i++) begin
         x = mod_product(x, x, n);
         if (x == n_less_one)
            return VERDICT_PROBABLE;
         if (x == 1)
            return VERDICT_COMPOSITE;
      end
      return VERDICT_COMPOSITE;
   endfunction

   assign verdicts_pending = verdict_queue.size();

   // predict on request transfer, compare on response transfer
   always @(posedge clock) begin
      logic [1:0] want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            verdict_queue.push_back(witness_verdict(req_candidate[NUM_WIDTH-1:0],
                                                    req_witness[NUM_WIDTH-1:0]));
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: unexpected verdict transfer, actual %0d", $time, rsp_verdict);
               fail_count <= fail_count + 1;
            end else begin
               want = verdict_queue.pop_front();
               if (want !== rsp_verdict) begin
                  $display("%0t: verdict mismatch, expected %0d, actual %0d",
                           $time, want, rsp_verdict);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: bench/tb_miller_rabin_witness_test_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_witness_test_unit
// Drives directed and random candidate/witness pairs into the unit with
// random idles on both channels; the checker predicts and compares verdicts.
// ----------------------------------------------------------------------------
module tb_miller_rabin_witness_test_unit;
   import mrw_pkg::*;

   localparam int RANDOM_ITEMS = 560;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_candidate;
   logic [63:0] req_witness;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_verdict;
   int          fail_count;
   int          verdicts_pending;
   logic        steady;

   miller_rabin_witness_test_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_candidate(req_candidate), .req_witness(req_witness),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_verdict(rsp_verdict)
   );

   mrw_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_candidate(req_candidate), .req_witness(req_witness),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_verdict(rsp_verdict),
      .fail_count(fail_count), .verdicts_pending(verdicts_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop
   initial begin
      #60_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // response side stalls at random with 7 percent chance, none while steady
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= steady || ($urandom_range(99) >= 7);
   end

   // present one pair and hold it until the transfer
   task automatic send_pair(logic [63:0] n, logic [63:0] a);
      if (!steady) begin
         while ($urandom_range(99) < 7) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_candidate <= n;
      req_witness   <= a;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [63:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   // valid pair: odd candidate, witness in 2..n-2
   task automatic send_valid(logic [63:0] n);
      send_pair(n, (wide_random() % (n - 64'd3)) + 64'd2);
   endtask

   initial begin
      int pick;
      logic [63:0] n;
      req_valid     <= 1'b0;
      req_candidate <= '0;
      req_witness   <= '0;
      steady        = 1'b0;
      reset         <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: range checks, tiny and huge candidates, known pseudoprimes
      send_pair(64'd0, 64'd2);
      send_pair(64'd3, 64'd2);
      send_pair(64'd4, 64'd2);
      send_pair(64'd100, 64'd3);
      send_pair(64'd5, 64'd2);
      send_pair(64'd5, 64'd3);
      send_pair(64'd5, 64'd1);
      send_pair(64'd5, 64'd4);
      send_pair(64'd97, 64'd0);
      send_pair(64'd97, 64'd95);
      send_pair(64'd97, 64'd96);
      send_pair(64'd561, 64'd2);
      send_pair(64'd2047, 64'd2);
      send_pair(64'd2047, 64'd3);
      send_pair(64'd3215031751, 64'd7);
      send_pair(64'hFFFF_FFFF_FFFF_FFC5, 64'd2);
      send_pair(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC3);
      send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFD);
      send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
      send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_pair(64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555);

      // random: mostly small valid pairs, a few wide ones, some noise
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 200 && i < 280);
         if (i == 300) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (verdicts_pending != 0)
               @(posedge clock);
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            n = (64'($urandom_range(4095, 2)) << 1) | 64'd1;
            send_valid(n);
         end else if (pick < 80) begin
            n = wide_random() | 64'd1;
            if (n < 5)
               n = 64'd5;
            send_valid(n);
         end else if (pick < 90) begin
            send_pair(wide_random(), wide_random());
         end else begin
            n = 64'($urandom_range(8191));
            send_pair(n, 64'($urandom_range(8191)));
         end
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      // drain: let the last transfer reach the checker first
      @(posedge clock);
      while (verdicts_pending != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
